FILE: rtl/varint_rpc_frame_parser_assert.svh
// assertion macros for the frame parser rtl
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef VARINT_RPC_FRAME_PARSER_ASSERT_SVH
`define VARINT_RPC_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define VRFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication
`define VRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

FILE: rtl/vrfp_pkg.sv
// shared types and constants of the varint frame parser
// no dependencies
package vrfp_pkg;

  localparam int unsigned VARINT_MAX_BYTES    = 5;
  localparam int unsigned LENGTH_PREFIX_BYTES = 4;
  localparam int unsigned MIN_FRAME           = 4;

  localparam int unsigned LEN_CNT_W = $clog2(LENGTH_PREFIX_BYTES);
  localparam int unsigned VIDX_W    = $clog2(VARINT_MAX_BYTES + 1);

  localparam logic [7:0] CONT_MASK = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7f;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_NUM  = 3'd1,
    PH_NLEN = 3'd2,
    PH_NAME = 3'd3,
    PH_PLEN = 3'd4,
    PH_PAY  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    K_NAME   = 2'd0,
    K_HEADER = 2'd1,
    K_PAY    = 2'd2,
    K_ERR    = 2'd3
  } kind_e;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_NUM_VAR   = 3'd2;
  localparam logic [2:0] ERR_NLEN_VAR  = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;
  localparam logic [2:0] ERR_PLEN_VAR  = 3'd5;
  localparam logic [2:0] ERR_MISMATCH  = 3'd6;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [31:0] msg_number;
    logic [31:0] name_length;
    logic [31:0] payload_length;
    logic [2:0]  error_code;
    logic        frame_end;
  } res_t;

endpackage

FILE: rtl/vrfp_out_buf.sv
// two-entry result buffer: output register plus skid stage
// depends on vrfp_pkg for the result type
module vrfp_out_buf import vrfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  res_t head_q, head_d;
  res_t skid_q, skid_d;
  logic head_valid_q, head_valid_d;
  logic skid_valid_q, skid_valid_d;
  logic pop;

  assign pop         = head_valid_q & out_ready_i;
  assign space_o     = ~skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (head_valid_q && !pop) begin
      if (push_i) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      head_d       = skid_q;
      head_valid_d = 1'b1;
      skid_d       = push_data_i;
      skid_valid_d = push_i;
    end else begin
      head_d       = push_data_i;
      head_valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

FILE: rtl/varint_rpc_frame_parser.sv
// frame parser for length-prefixed frames with leb128 varint header fields
// depends on vrfp_pkg, vrfp_out_buf and varint_rpc_frame_parser_assert.svh
//
// rx channel (rx_valid_i / rx_ready_o / rx_byte_i): one received byte per transfer.
// res channel (res_valid_o / res_ready_i and the result fields): at most one
// result per byte; name bytes, one header result, payload bytes, or an error.
// each byte is decoded in the cycle it is taken and its result is registered
// into the output buffer; one byte per cycle while rx_ready_o stays high.
// the per-byte path is three 32-bit adders and compares plus the varint shift-or.
// results go through an output register and a skid stage, so rx_ready_o only
// drops once both hold a result the receiver has not taken; it returns the
// cycle after the receiver takes one. while both are full every byte waits,
// even one that makes no result.
// after reset the parser expects the first length byte and both result slots
// are empty. after a frame error the parser keeps taking bytes and drops them
// until the next reset.
`include "varint_rpc_frame_parser_assert.svh"

module varint_rpc_frame_parser import vrfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] msg_number_o,
  output logic [31:0] name_length_o,
  output logic [31:0] payload_length_o,
  output logic [2:0]  error_code_o,
  output logic        frame_end_o
);

  localparam logic [LEN_CNT_W-1:0] LEN_LAST  = LEN_CNT_W'(LENGTH_PREFIX_BYTES - 1);
  localparam logic [VIDX_W-1:0]    VIDX_LAST = VIDX_W'(VARINT_MAX_BYTES - 1);

  phase_e                phase_q, phase_d;
  logic [LEN_CNT_W-1:0]  len_cnt_q, len_cnt_d;
  logic [31:0]           frame_len_q, frame_len_d;
  logic [31:0]           seen_q, seen_d;
  logic [31:0]           accum_q, accum_d;
  logic [VIDX_W-1:0]     vidx_q, vidx_d;
  logic [31:0]           number_q, number_d;
  logic [31:0]           nlen_q, nlen_d;
  logic [31:0]           plen_q, plen_d;
  logic [31:0]           field_rem_q, field_rem_d;
  logic                  halted_q, halted_d;

  logic        accept;
  logic        buf_space;
  logic [31:0] seen_inc;
  logic [31:0] rem;
  logic [31:0] field_dec;
  logic [31:0] len_part;
  logic [31:0] len_base;
  logic [5:0]  vshift;
  logic [31:0] vpart;
  logic [31:0] value;
  logic [2:0]  var_err;
  logic        res_push;
  logic        fail;
  logic [2:0]  fail_code;
  kind_e       res_kind;
  logic        res_end;
  res_t        res;
  res_t        out_res;

  assign rx_ready_o = buf_space;
  assign accept     = rx_valid_i & rx_ready_o;
  assign seen_inc   = seen_q + 32'd1;
  assign rem        = frame_len_q - seen_inc;
  assign field_dec  = field_rem_q - 32'd1;
  assign len_part   = {24'd0, rx_byte_i} << {len_cnt_q, 3'b000};
  assign vshift     = {3'd0, vidx_q} * 6'd7;
  assign vpart      = {24'd0, rx_byte_i & DATA_MASK} << vshift;
  assign value      = accum_q | vpart;

  always_comb begin
    unique case (phase_q)
      PH_NUM:  var_err = ERR_NUM_VAR;
      PH_NLEN: var_err = ERR_NLEN_VAR;
      default: var_err = ERR_PLEN_VAR;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    len_cnt_d   = len_cnt_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    accum_d     = accum_q;
    vidx_d      = vidx_q;
    number_d    = number_q;
    nlen_d      = nlen_q;
    plen_d      = plen_q;
    field_rem_d = field_rem_q;
    halted_d    = halted_q;
    len_base    = frame_len_q;
    res_push    = 1'b0;
    fail        = 1'b0;
    fail_code   = ERR_NONE;
    res_kind    = K_NAME;
    res_end     = 1'b0;
    if (accept && !halted_q) begin
      unique case (phase_q)
        PH_LEN: begin
          if (len_cnt_q == '0) begin
            len_base = '0;
            number_d = '0;
            nlen_d   = '0;
            plen_d   = '0;
          end
          frame_len_d = len_base | len_part;
          if (len_cnt_q == LEN_LAST) begin
            len_cnt_d = '0;
            if (frame_len_d < 32'(MIN_FRAME)) begin
              fail      = 1'b1;
              fail_code = ERR_SHORT;
            end else begin
              phase_d = PH_NUM;
              seen_d  = '0;
              accum_d = '0;
              vidx_d  = '0;
            end
          end else begin
            len_cnt_d = len_cnt_q + 1'b1;
          end
        end
        PH_NAME: begin
          seen_d      = seen_inc;
          field_rem_d = field_dec;
          res_push    = 1'b1;
          res_kind    = K_NAME;
          if (field_dec == '0) begin
            phase_d = PH_PLEN;
            accum_d = '0;
            vidx_d  = '0;
          end
        end
        PH_PAY: begin
          seen_d      = seen_inc;
          field_rem_d = field_dec;
          res_push    = 1'b1;
          res_kind    = K_PAY;
          if (field_dec == '0) begin
            res_end     = 1'b1;
            phase_d     = PH_LEN;
            len_cnt_d   = '0;
            seen_d      = '0;
            field_rem_d = '0;
          end
        end
        PH_NUM, PH_NLEN, PH_PLEN: begin
          seen_d = seen_inc;
          if ((rx_byte_i & CONT_MASK) != '0) begin
            accum_d = value;
            vidx_d  = vidx_q + 1'b1;
            if (vidx_q == VIDX_LAST || seen_inc >= frame_len_q) begin
              fail      = 1'b1;
              fail_code = var_err;
            end
          end else begin
            accum_d = '0;
            vidx_d  = '0;
            priority if (phase_q == PH_NUM) begin
              number_d = value;
              if (rem == '0) begin
                fail      = 1'b1;
                fail_code = ERR_NLEN_VAR;
              end else begin
                phase_d = PH_NLEN;
              end
            end else if (phase_q == PH_NLEN) begin
              nlen_d = value;
              priority if (value > rem) begin
                fail      = 1'b1;
                fail_code = ERR_OVERRUN;
              end else if (value == rem) begin
                fail      = 1'b1;
                fail_code = ERR_PLEN_VAR;
              end else begin
                field_rem_d = value;
                phase_d     = (value == '0) ? PH_PLEN : PH_NAME;
              end
            end else begin
              plen_d = value;
              if (value != rem) begin
                fail      = 1'b1;
                fail_code = ERR_MISMATCH;
              end else begin
                res_push = 1'b1;
                res_kind = K_HEADER;
                if (value == '0) begin
                  res_end     = 1'b1;
                  phase_d     = PH_LEN;
                  len_cnt_d   = '0;
                  seen_d      = '0;
                  field_rem_d = '0;
                end else begin
                  field_rem_d = value;
                  phase_d     = PH_PAY;
                end
              end
            end
          end
        end
        default: begin
          phase_d     = PH_LEN;
          len_cnt_d   = '0;
          seen_d      = '0;
          field_rem_d = '0;
        end
      endcase
      if (fail) begin
        halted_d = 1'b1;
        res_push = 1'b1;
        res_kind = K_ERR;
        res_end  = 1'b1;
      end
    end
  end

  always_comb begin
    res.kind           = res_kind;
    res.data_byte      = (res_kind == K_NAME || res_kind == K_PAY) ? rx_byte_i : 8'd0;
    res.msg_number     = number_d;
    res.name_length    = nlen_d;
    res.payload_length = plen_d;
    res.error_code     = fail_code;
    res.frame_end      = res_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      len_cnt_q   <= '0;
      frame_len_q <= '0;
      seen_q      <= '0;
      accum_q     <= '0;
      vidx_q      <= '0;
      number_q    <= '0;
      nlen_q      <= '0;
      plen_q      <= '0;
      field_rem_q <= '0;
      halted_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_cnt_q   <= len_cnt_d;
      frame_len_q <= frame_len_d;
      seen_q      <= seen_d;
      accum_q     <= accum_d;
      vidx_q      <= vidx_d;
      number_q    <= number_d;
      nlen_q      <= nlen_d;
      plen_q      <= plen_d;
      field_rem_q <= field_rem_d;
      halted_q    <= halted_d;
    end
  end

  vrfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .space_o     (buf_space),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .out_data_o  (out_res)
  );

  assign kind_o           = out_res.kind;
  assign data_byte_o      = out_res.data_byte;
  assign msg_number_o     = out_res.msg_number;
  assign name_length_o    = out_res.name_length;
  assign payload_length_o = out_res.payload_length;
  assign error_code_o     = out_res.error_code;
  assign frame_end_o      = out_res.frame_end;

  // once halted, stays halted and produces nothing
  `VRFP_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `VRFP_ASSERT_IMPL(a_no_result_halted, halted_q, !res_push)
  // an error result always halts the parser and closes the frame
  `VRFP_ASSERT_IMPL(a_err_halts, res_push && res_kind == K_ERR, halted_d && res_end)
  // varint byte index never exceeds its last index while running
  `VRFP_ASSERT_IMPL(a_vidx_range, !halted_q, vidx_q <= VIDX_LAST)
  // in the length and message-number phases no field count is pending
  `VRFP_ASSERT_IMPL(a_field_idle, !halted_q && (phase_q == PH_LEN || phase_q == PH_NUM),
                    field_rem_q == '0)

endmodule
